FILE: hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and arithmetic helpers for the scan cluster block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_SCAN_POINTS = 4096;
    localparam int TRIG_BITS       = 16;
    localparam int CORDIC_ITERS    = 22;
    localparam int CW              = 34;   // CORDIC x/y width, Q2.30 plus headroom
    localparam int ZW              = 26;   // CORDIC angle accumulator width
    localparam int IW              = 5;    // iteration counter width
    localparam int SUMW            = 30;
    localparam int CNTW            = 13;
    localparam int PW              = 18;   // point coordinate width
    localparam int DVW             = 30;   // divider dividend width
    localparam int CIDXW           = 8;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int TRIG_SHIFT = 31 - TRIG_BITS;
    localparam logic signed [CW-1:0] TRIG_LIM = CW'((1 << (TRIG_BITS - 1)) - 1);

    localparam logic [CIDXW-1:0] REG_RANGE_LOW   = 8'd0;
    localparam logic [CIDXW-1:0] REG_RANGE_HIGH  = 8'd1;
    localparam logic [CIDXW-1:0] REG_JOIN_DIST   = 8'd2;
    localparam logic [CIDXW-1:0] REG_MIN_POINTS  = 8'd3;
    localparam logic [CIDXW-1:0] REG_START_ANGLE = 8'd4;
    localparam logic [CIDXW-1:0] REG_ANGLE_STEP  = 8'd5;

    typedef struct packed {
        logic [15:0]     range_low_mm;
        logic [15:0]     range_high_mm;
        logic [15:0]     join_distance_mm;
        logic [CNTW-1:0] min_cluster_points;
        logic [15:0]     start_angle;
        logic [15:0]     angle_step;
    } cfg_t;

    // One closed cluster (or a bare scan end when count is zero).
    typedef struct packed {
        logic signed [SUMW-1:0] sum_x;
        logic signed [SUMW-1:0] sum_y;
        logic [CNTW-1:0]        count;
        logic                   valid;
        logic                   last;
    } qent_t;

    function automatic logic signed [ZW-1:0] atan_at(input logic [IW-1:0] i);
        logic signed [ZW-1:0] r;
        r = '0;
        unique case (i)
            5'd0:  r = 26'sd2097152;
            5'd1:  r = 26'sd1238021;
            5'd2:  r = 26'sd654136;
            5'd3:  r = 26'sd332050;
            5'd4:  r = 26'sd166669;
            5'd5:  r = 26'sd83416;
            5'd6:  r = 26'sd41718;
            5'd7:  r = 26'sd20860;
            5'd8:  r = 26'sd10430;
            5'd9:  r = 26'sd5215;
            5'd10: r = 26'sd2608;
            5'd11: r = 26'sd1304;
            5'd12: r = 26'sd652;
            5'd13: r = 26'sd326;
            5'd14: r = 26'sd163;
            5'd15: r = 26'sd81;
            5'd16: r = 26'sd41;
            5'd17: r = 26'sd20;
            5'd18: r = 26'sd10;
            5'd19: r = 26'sd5;
            5'd20: r = 26'sd3;
            5'd21: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round a Q2.30 CORDIC output to the trig format and clamp it symmetrically.
    function automatic logic signed [TRIG_BITS-1:0] trig_scale(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + CW'(1 << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        if (t > TRIG_LIM) t = TRIG_LIM;
        if (t < -TRIG_LIM) t = -TRIG_LIM;
        return t[TRIG_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/scc_queue.sv
// ----------------------------------------------------------------------------
// scc_queue
// Small FIFO of closed clusters between the front and back ends.
// ----------------------------------------------------------------------------
module scc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  scc_pkg::qent_t push_data,
    output logic          full,
    input  logic          pop,
    output scc_pkg::qent_t head,
    output logic          empty
);
    scc_pkg::qent_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full  = (cnt_reg == 3'd4);
    assign empty = (cnt_reg == 3'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full) wp_reg <= wp_reg + 2'd1;
            if (pop && !empty) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push && !full) - 3'(pop && !empty);
        end
    end
endmodule

FILE: hw/rtl/scc_front.sv
// ----------------------------------------------------------------------------
// scc_front
// Accepts samples, converts in-window ones to x/y with an iterative CORDIC,
// applies the jump-distance test and pushes closed clusters into the queue.
// ----------------------------------------------------------------------------
module scc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  scc_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_range_mm,
    input  logic                s_scan_end,
    output logic                q_push,
    output scc_pkg::qent_t      q_data,
    input  logic                q_full
);
    typedef enum logic [7:0] {
        F_IDLE   = 8'b0000_0001,
        F_CORDIC = 8'b0000_0010,
        F_MUL    = 8'b0000_0100,
        F_ROUND  = 8'b0000_1000,
        F_SQ     = 8'b0001_0000,
        F_DECIDE = 8'b0010_0000,
        F_EMIT1  = 8'b0100_0000,
        F_EMIT2  = 8'b1000_0000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [15:0] range_reg;
    logic        end_reg;
    logic        mid_scan_reg;
    logic [15:0] phase_reg;
    logic [1:0]  quad_reg;
    logic [scc_pkg::IW-1:0] iter_reg;
    logic signed [scc_pkg::CW-1:0] cx_reg, cy_reg;
    logic signed [scc_pkg::ZW-1:0] cz_reg;
    logic signed [32:0] prodx_reg, prody_reg;
    logic signed [scc_pkg::PW-1:0] px_reg, py_reg, prevx_reg, prevy_reg;
    logic [37:0] sqx_reg, sqy_reg;
    logic [31:0] j2_reg;
    logic signed [scc_pkg::SUMW-1:0] sumx_reg, sumy_reg, gsx_reg, gsy_reg;
    logic [scc_pkg::CNTW-1:0] cnt_reg, gcnt_reg;
    logic gap_q_reg;

    logic [15:0] angle;
    logic [1:0]  quad;
    logic [23:0] zt;
    logic        accept;
    logic        in_win;
    logic signed [15:0] cc, ss, tc, ts;
    logic signed [scc_pkg::CW-1:0] xs, ys;
    logic signed [18:0] dx, dy;
    logic signed [37:0] dx2, dy2;
    logic [38:0] d2;
    logic [scc_pkg::CNTW-1:0] need;
    logic gap, end_q;

    // Round to nearest with ties away from zero, on the magnitude.
    function automatic logic signed [scc_pkg::PW-1:0] round_coord(input logic signed [32:0] p);
        logic [32:0] mag;
        logic [32:0] m;
        mag = p[32] ? 33'(-p) : 33'(p);
        m   = (mag + 33'(1 << (scc_pkg::TRIG_BITS - 2))) >> (scc_pkg::TRIG_BITS - 1);
        return p[32] ? -scc_pkg::PW'(m) : scc_pkg::PW'(m);
    endfunction

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;
    assign angle   = mid_scan_reg ? phase_reg : cfg.start_angle;
    assign quad    = 2'((angle + 16'h2000) >> 14);
    assign zt      = {angle, 8'h00} - {quad, 22'h0};
    assign in_win  = (s_range_mm >= cfg.range_low_mm) && (s_range_mm <= cfg.range_high_mm);

    assign xs = cx_reg >>> iter_reg;
    assign ys = cy_reg >>> iter_reg;
    assign cc = scc_pkg::trig_scale(cx_reg);
    assign ss = scc_pkg::trig_scale(cy_reg);

    always_comb begin
        unique case (quad_reg)
            2'd0: begin tc = cc;  ts = ss;  end
            2'd1: begin tc = -ss; ts = cc;  end
            2'd2: begin tc = -cc; ts = -ss; end
            default: begin tc = ss; ts = -cc; end
        endcase
    end

    assign dx  = 19'(px_reg) - 19'(prevx_reg);
    assign dy  = 19'(py_reg) - 19'(prevy_reg);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign d2  = 39'(sqx_reg) + 39'(sqy_reg);
    assign need = (cfg.min_cluster_points == '0) ? scc_pkg::CNTW'(1) : cfg.min_cluster_points;
    assign gap  = (cnt_reg != '0) &&
                  ((d2 > 39'(j2_reg)) || (cnt_reg >= scc_pkg::CNTW'(scc_pkg::MAX_SCAN_POINTS)));
    // Whether the cluster still open at scan end will be reported.
    assign end_q = (cnt_reg != '0) && (cnt_reg >= need);

    always_comb begin
        q_push = 1'b0;
        q_data = '0;
        if (state_reg == F_EMIT1 && gap_q_reg) begin
            q_push       = 1'b1;
            q_data.sum_x = gsx_reg;
            q_data.sum_y = gsy_reg;
            q_data.count = gcnt_reg;
            q_data.valid = 1'b1;
            q_data.last  = end_reg && !end_q;
        end else if (state_reg == F_EMIT2 && (end_q || !gap_q_reg)) begin
            q_push       = 1'b1;
            q_data.sum_x = end_q ? sumx_reg : '0;
            q_data.sum_y = end_q ? sumy_reg : '0;
            q_data.count = end_q ? cnt_reg : '0;
            q_data.valid = end_q;
            q_data.last  = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:   if (accept) state_next = in_win ? F_CORDIC : F_EMIT1;
            F_CORDIC: if (iter_reg == scc_pkg::IW'(scc_pkg::CORDIC_ITERS - 1)) state_next = F_MUL;
            F_MUL:    state_next = F_ROUND;
            F_ROUND:  state_next = F_SQ;
            F_SQ:     state_next = F_DECIDE;
            F_DECIDE: state_next = F_EMIT1;
            F_EMIT1:  if (!(gap_q_reg && q_full)) state_next = end_reg ? F_EMIT2 : F_IDLE;
            F_EMIT2:  if (!(q_push && q_full)) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            mid_scan_reg <= 1'b0;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            sumx_reg     <= '0;
            sumy_reg     <= '0;
            prevx_reg    <= '0;
            prevy_reg    <= '0;
            gap_q_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                phase_reg    <= angle + cfg.angle_step;
                mid_scan_reg <= !s_scan_end;
                gap_q_reg    <= 1'b0;
            end
            if (state_reg == F_DECIDE) begin
                gap_q_reg <= gap && (cnt_reg >= need);
                sumx_reg  <= (gap ? '0 : sumx_reg) + scc_pkg::SUMW'(px_reg);
                sumy_reg  <= (gap ? '0 : sumy_reg) + scc_pkg::SUMW'(py_reg);
                cnt_reg   <= gap ? scc_pkg::CNTW'(1) : cnt_reg + scc_pkg::CNTW'(1);
                prevx_reg <= px_reg;
                prevy_reg <= py_reg;
            end
            if (state_reg == F_EMIT2 && !(q_push && q_full)) begin
                cnt_reg  <= '0;
                sumx_reg <= '0;
                sumy_reg <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        j2_reg <= cfg.join_distance_mm * cfg.join_distance_mm;
        if (accept) begin
            range_reg <= s_range_mm;
            end_reg   <= s_scan_end;
            quad_reg  <= quad;
            cz_reg    <= scc_pkg::ZW'(signed'(zt));
            cx_reg    <= scc_pkg::CORDIC_GAIN;
            cy_reg    <= '0;
            iter_reg  <= '0;
        end
        if (state_reg == F_CORDIC) begin
            if (cz_reg >= 0) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - scc_pkg::atan_at(iter_reg);
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + scc_pkg::atan_at(iter_reg);
            end
            iter_reg <= iter_reg + scc_pkg::IW'(1);
        end
        if (state_reg == F_MUL) begin
            prodx_reg <= $signed({1'b0, range_reg}) * tc;
            prody_reg <= $signed({1'b0, range_reg}) * ts;
        end
        if (state_reg == F_ROUND) begin
            px_reg <= round_coord(prodx_reg);
            py_reg <= round_coord(prody_reg);
        end
        if (state_reg == F_SQ) begin
            sqx_reg <= 38'(dx2);
            sqy_reg <= 38'(dy2);
        end
        if (state_reg == F_DECIDE) begin
            gsx_reg  <= sumx_reg;
            gsy_reg  <= sumy_reg;
            gcnt_reg <= cnt_reg;
        end
    end
endmodule

FILE: hw/rtl/scc_back.sv
// ----------------------------------------------------------------------------
// scc_back
// Pops queue words, divides both sums by the point count with a bit-serial
// restoring divider, skipped for a bare scan end, and presents the result word.
// ----------------------------------------------------------------------------
module scc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scc_pkg::qent_t       head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [16:0]   m_centroid_x,
    output logic signed [16:0]   m_centroid_y,
    output logic [12:0]          m_point_total,
    output logic                 m_cluster_valid,
    output logic                 m_last_of_scan
);
    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t state_reg;
    logic [scc_pkg::DVW-1:0]  qx_reg, qy_reg;
    logic [scc_pkg::CNTW:0]   rx_reg, ry_reg;
    logic [scc_pkg::CNTW-1:0] div_reg;
    logic                     nx_reg, ny_reg, valid_reg, last_reg;
    logic [scc_pkg::IW-1:0]   iter_reg;

    logic [scc_pkg::CNTW:0] tx, ty;
    logic bx, by;

    assign q_pop   = (state_reg == B_IDLE) && !q_empty;
    assign m_valid = (state_reg == B_OUT);

    assign tx = {rx_reg[scc_pkg::CNTW-1:0], qx_reg[scc_pkg::DVW-1]};
    assign ty = {ry_reg[scc_pkg::CNTW-1:0], qy_reg[scc_pkg::DVW-1]};
    assign bx = (tx >= {1'b0, div_reg});
    assign by = (ty >= {1'b0, div_reg});

    assign m_point_total   = div_reg;
    assign m_cluster_valid = valid_reg;
    assign m_last_of_scan  = last_reg;
    assign m_centroid_x    = nx_reg ? -17'(qx_reg) : 17'(qx_reg);
    assign m_centroid_y    = ny_reg ? -17'(qy_reg) : 17'(qy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE: if (q_pop) state_reg <= (head.count == '0) ? B_OUT : B_DIV;
                B_DIV:  if (iter_reg == scc_pkg::IW'(scc_pkg::DVW - 1)) state_reg <= B_OUT;
                B_OUT:  if (m_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            nx_reg    <= head.sum_x[scc_pkg::SUMW-1];
            ny_reg    <= head.sum_y[scc_pkg::SUMW-1];
            qx_reg    <= head.sum_x[scc_pkg::SUMW-1] ? scc_pkg::DVW'(-head.sum_x)
                                                     : scc_pkg::DVW'(head.sum_x);
            qy_reg    <= head.sum_y[scc_pkg::SUMW-1] ? scc_pkg::DVW'(-head.sum_y)
                                                     : scc_pkg::DVW'(head.sum_y);
            rx_reg    <= '0;
            ry_reg    <= '0;
            div_reg   <= head.count;
            valid_reg <= head.valid;
            last_reg  <= head.last;
            iter_reg  <= '0;
        end else if (state_reg == B_DIV) begin
            // The quotient bits shift into the dividend register from the bottom.
            rx_reg   <= bx ? tx - {1'b0, div_reg} : tx;
            ry_reg   <= by ? ty - {1'b0, div_reg} : ty;
            qx_reg   <= {qx_reg[scc_pkg::DVW-2:0], bx};
            qy_reg   <= {qy_reg[scc_pkg::DVW-2:0], by};
            iter_reg <= iter_reg + scc_pkg::IW'(1);
        end
    end
endmodule

FILE: hw/rtl/scan_cluster_centroids_top.sv
// ----------------------------------------------------------------------------
// scan_cluster_centroids_top
// Laser scan segmentation by jump distance, reporting cluster centroids.
// ----------------------------------------------------------------------------
// A sample in the range window holds the front end through the accept, the
// CORDIC iterations, multiply, round, square, decide and the emit state that
// posts a closed cluster, and a second emit state when it ends a scan; a
// sample outside the window skips from the accept to the emit states. Each
// cluster word costs a pop and the back end's bit-serial divider plus the
// output handshake; a bare scan-end word skips the divider. A full four-word
// queue stalls the front end, and the queue lets the two ends run apart.
module scan_cluster_centroids_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_range_mm,
    input  logic               s_scan_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_centroid_x,
    output logic signed [16:0] m_centroid_y,
    output logic [12:0]        m_point_total,
    output logic               m_cluster_valid,
    output logic               m_last_of_scan
);
    scc_pkg::cfg_t  cfg_reg;
    scc_pkg::qent_t q_in, q_head;
    logic q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_low_mm       <= 16'd20;
            cfg_reg.range_high_mm      <= 16'd30000;
            cfg_reg.join_distance_mm   <= 16'd30;
            cfg_reg.min_cluster_points <= 13'd3;
            cfg_reg.start_angle        <= 16'd0;
            cfg_reg.angle_step         <= 16'd182;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                scc_pkg::REG_RANGE_LOW:   cfg_reg.range_low_mm       <= cfg_data;
                scc_pkg::REG_RANGE_HIGH:  cfg_reg.range_high_mm      <= cfg_data;
                scc_pkg::REG_JOIN_DIST:   cfg_reg.join_distance_mm   <= cfg_data;
                scc_pkg::REG_MIN_POINTS:  cfg_reg.min_cluster_points <= cfg_data[12:0];
                scc_pkg::REG_START_ANGLE: cfg_reg.start_angle        <= cfg_data;
                scc_pkg::REG_ANGLE_STEP:  cfg_reg.angle_step         <= cfg_data;
                default: ;
            endcase
        end
    end

    scc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_range_mm (s_range_mm),
        .s_scan_end (s_scan_end),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    scc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    scc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (q_head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_centroid_x    (m_centroid_x),
        .m_centroid_y    (m_centroid_y),
        .m_point_total   (m_point_total),
        .m_cluster_valid (m_cluster_valid),
        .m_last_of_scan  (m_last_of_scan)
    );
endmodule

FILE: sim/tb_scan_cluster_centroids_top.sv
// ----------------------------------------------------------------------------
// tb_scan_cluster_centroids_top
// Self-checking bench for the scan cluster block: a cycle-free predictor
// computes the expected cluster words for each accepted sample, and a monitor
// compares every result word field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_scan_cluster_centroids_top;

    localparam logic [scc_pkg::CIDXW-1:0] REG_UNMAPPED = 8'd9;
    localparam longint ARC_TAB [22] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    typedef struct {
        logic [15:0] range_mm;
        logic        scan_end;
    } sample_t;

    typedef struct {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic [12:0]        total;
        logic               cvalid;
        logic               last;
    } cluster_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_range_mm = '0;
    logic s_scan_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [16:0] m_centroid_x;
    logic signed [16:0] m_centroid_y;
    logic [12:0] m_point_total;
    logic m_cluster_valid;
    logic m_last_of_scan;

    scan_cluster_centroids_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_range_mm(s_range_mm), .s_scan_end(s_scan_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_centroid_x(m_centroid_x), .m_centroid_y(m_centroid_y),
        .m_point_total(m_point_total), .m_cluster_valid(m_cluster_valid),
        .m_last_of_scan(m_last_of_scan)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sample_t       pending_samples[$];
    cluster_word_t expected_clusters[$];
    int            errors = 0;
    int            idle_pct = 25;
    int            samples_sent = 0;
    int            words_seen = 0;
    int            clusters_seen = 0;

    // Predictor copy of the registers and the scan state.
    logic [15:0] win_low = 16'd20, win_high = 16'd30000, join_mm = 16'd30;
    logic [12:0] min_pts = 13'd3;
    logic [15:0] first_angle = 16'd0, step_angle = 16'd182;
    logic [15:0] phase_acc = '0;
    bit          in_scan = 0;
    longint      last_x = 0, last_y = 0, acc_x = 0, acc_y = 0, pts = 0;

    function automatic longint trig_round(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 14)) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        return r;
    endfunction

    function automatic void sin_cos(input logic [15:0] ph, output longint c, output longint s);
        longint p, q, z, x, y, nx, ny, cc, ss;
        p = longint'(ph) << 8;
        q = ((p + 64'sh200000) >> 22) & 3;
        z = (p - q * 64'sh400000) & 64'shFFFFFF;
        if (z >= 64'sh800000) z -= 64'sh1000000;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 22; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_TAB[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_TAB[i];
            end
            x = nx; y = ny;
        end
        cc = trig_round(x);
        ss = trig_round(y);
        case (q)
            0: begin c = cc;  s = ss;  end
            1: begin c = -ss; s = cc;  end
            2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic longint project(input longint r, input longint t);
        longint prod, mag;
        prod = r * t;
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + (64'sd1 <<< 14)) >> 15;
        return (prod < 0) ? -mag : mag;
    endfunction

    function automatic void close_cluster(ref cluster_word_t words[$]);
        longint need;
        cluster_word_t w;
        need = (min_pts == 0) ? 1 : longint'(min_pts);
        if (pts != 0 && pts >= need) begin
            w.cx = 17'(acc_x / pts);
            w.cy = 17'(acc_y / pts);
            w.total = 13'(pts);
            w.cvalid = 1'b1;
            w.last = 1'b0;
            words.insert(words.size(), w);
        end
        pts = 0; acc_x = 0; acc_y = 0;
    endfunction

    function automatic void predict_sample(input sample_t smp);
        logic [15:0] ang;
        longint c, s, x, y, dx, dy;
        cluster_word_t words[$];
        cluster_word_t w;
        ang = in_scan ? phase_acc : first_angle;
        phase_acc = ang + step_angle;
        in_scan = 1;
        if (smp.range_mm >= win_low && smp.range_mm <= win_high) begin
            sin_cos(ang, c, s);
            x = project(longint'(smp.range_mm), c);
            y = project(longint'(smp.range_mm), s);
            if (pts != 0) begin
                dx = x - last_x; dy = y - last_y;
                if (dx * dx + dy * dy > longint'(join_mm) * longint'(join_mm)
                        || pts >= scc_pkg::MAX_SCAN_POINTS)
                    close_cluster(words);
            end
            acc_x += x; acc_y += y; pts++;
            last_x = x; last_y = y;
        end
        if (smp.scan_end) begin
            close_cluster(words);
            if (words.size() == 0) begin
                w = '{cx: '0, cy: '0, total: '0, cvalid: 1'b0, last: 1'b0};
                words.insert(words.size(), w);
            end
            words[words.size() - 1].last = 1'b1;
            in_scan = 0;
            phase_acc = first_angle;
        end
        foreach (words[i]) expected_clusters.insert(expected_clusters.size(), words[i]);
    endfunction

    // Sample driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sample('{range_mm: s_range_mm, scan_end: s_scan_end});
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_range_mm <= pending_samples[0].range_mm;
                    s_scan_end <= pending_samples[0].scan_end;
                    void'(pending_samples.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        cluster_word_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_clusters.size() == 0) begin
                    $error("unexpected result word x=%0d y=%0d n=%0d",
                           m_centroid_x, m_centroid_y, m_point_total);
                    errors++;
                end else begin
                    e = expected_clusters.pop_front();
                    if (e.cvalid) clusters_seen++;
                    if (m_centroid_x !== e.cx) begin
                        $error("centroid_x expected %0d got %0d", e.cx, m_centroid_x);
                        errors++;
                    end
                    if (m_centroid_y !== e.cy) begin
                        $error("centroid_y expected %0d got %0d", e.cy, m_centroid_y);
                        errors++;
                    end
                    if (m_point_total !== e.total) begin
                        $error("point_total expected %0d got %0d", e.total, m_point_total);
                        errors++;
                    end
                    if (m_cluster_valid !== e.cvalid) begin
                        $error("cluster_valid expected %0d got %0d", e.cvalid,
                               m_cluster_valid);
                        errors++;
                    end
                    if (m_last_of_scan !== e.last) begin
                        $error("last_of_scan expected %0d got %0d", e.last, m_last_of_scan);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            scc_pkg::REG_RANGE_LOW:   win_low = val;
            scc_pkg::REG_RANGE_HIGH:  win_high = val;
            scc_pkg::REG_JOIN_DIST:   join_mm = val;
            scc_pkg::REG_MIN_POINTS:  min_pts = val[12:0];
            scc_pkg::REG_START_ANGLE: first_angle = val;
            scc_pkg::REG_ANGLE_STEP:  step_angle = val;
            default: ;
        endcase
    endtask

    task automatic add(input int r, input bit e);
        pending_samples.insert(pending_samples.size(), '{range_mm: 16'(r), scan_end: e});
    endtask

    // The block may still be chewing on a sample that yields nothing, so allow
    // the front-end latency to pass before touching the registers.
    task automatic drain();
        wait (pending_samples.size() == 0 && !s_valid && expected_clusters.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    // A random scan: mostly smooth walls with occasional jumps and dropouts.
    task automatic add_scan(input int len);
        int r;
        r = $urandom_range(200, 4000);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(19))
                0: r = $urandom_range(100, 20000);
                1: add($urandom_range(0, 65535), (i == len - 1));
                2: add($urandom_range(0, 15), (i == len - 1));
                default: begin
                    r = r + $urandom_range(0, 20) - 10;
                    if (r < 50) r = 50;
                end
            endcase
            add(r, (i == len - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: window edges, field extremes, a bare scan end.
        add(0, 0); add(19, 0); add(20, 0); add(30000, 0); add(30001, 0);
        add(65535, 0); add(1000, 0); add(1001, 0); add(1002, 0); add(1003, 1);
        add(500, 1);
        add(0, 1);
        drain();

        // Widest window and largest minimum: one long cluster is too small to report.
        write_reg(scc_pkg::REG_RANGE_LOW, 16'd0);
        write_reg(scc_pkg::REG_RANGE_HIGH, 16'd65535);
        write_reg(scc_pkg::REG_JOIN_DIST, 16'd65535);
        write_reg(scc_pkg::REG_MIN_POINTS, 13'd4096);
        write_reg(scc_pkg::REG_START_ANGLE, 16'h8000);
        write_reg(scc_pkg::REG_ANGLE_STEP, 16'd0);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        for (int i = 0; i < 40; i++) add(65535 - (i & 1), (i == 39));
        drain();

        // Inverted window keeps nothing.
        write_reg(scc_pkg::REG_RANGE_LOW, 16'd500);
        write_reg(scc_pkg::REG_RANGE_HIGH, 16'd100);
        add(300, 0); add(50, 0); add(700, 1);
        drain();

        // Zero minimum and zero join distance: only coincident points join.
        write_reg(scc_pkg::REG_RANGE_LOW, 16'd0);
        write_reg(scc_pkg::REG_RANGE_HIGH, 16'd65535);
        write_reg(scc_pkg::REG_JOIN_DIST, 16'd0);
        write_reg(scc_pkg::REG_MIN_POINTS, 13'd0);
        write_reg(scc_pkg::REG_START_ANGLE, 16'hFFFF);
        write_reg(scc_pkg::REG_ANGLE_STEP, 16'hFFFF);
        add(1000, 0); add(1000, 0); add(65535, 0); add(0, 0); add(32768, 1);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph == 2) ? 0 : 25;
            write_reg(scc_pkg::REG_RANGE_LOW, 16'($urandom_range(0, 100)));
            write_reg(scc_pkg::REG_RANGE_HIGH, 16'($urandom_range(15000, 65535)));
            write_reg(scc_pkg::REG_JOIN_DIST, 16'($urandom_range(20, 300)));
            write_reg(scc_pkg::REG_MIN_POINTS, 13'($urandom_range(1, 5)));
            write_reg(scc_pkg::REG_START_ANGLE, 16'($urandom));
            write_reg(scc_pkg::REG_ANGLE_STEP, 16'($urandom_range(50, 400)));
            while (pending_samples.size() < 230) add_scan($urandom_range(5, 60));
            drain();
        end

        $display("Sent %0d samples over several register settings, checked %0d words",
                 samples_sent, words_seen);
        $display("including %0d cluster centroids.", clusters_seen);
        if (errors == 0 && expected_clusters.size() == 0)
            $display("[scan_cluster_centroids_top] OK");
        else
            $display("[scan_cluster_centroids_top] ERROR");
        $finish;
    end

    initial begin
        #(12 * 4_000_000);
        $display("[scan_cluster_centroids_top] ERROR");
        $finish;
    end

endmodule
